// ===== rtl/core/mbre_pkg.sv =====
package mbre_pkg;

    localparam int LANES      = 8;
    localparam int EVENTS     = LANES + 1;
    localparam int POS_BITS   = 4;
    localparam int LANE_BITS  = 3;
    localparam int LEN_BITS   = 16;
    localparam int CFG_BITS   = 32;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_START_X          = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_Y          = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_WIDTH        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BIT_OFFSET       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_COLOR       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_COLOR        = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_TRANSPARENT = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_TRANSPARENT  = 3'd7;

    // per-byte event summary, event i < LANES is a run break before pixel i,
    // event LANES is the row end after the last used pixel
    typedef struct packed {
        logic [EVENTS-1:0]    bnd;
        logic [EVENTS-1:0]    emit;
        logic [EVENTS-1:0]    cbit;
        logic [LANE_BITS-1:0] first;
        logic [POS_BITS-1:0]  pend_pos;
    } mbre_evt_t;

endpackage

// ===== rtl/core/mono_bitmap_run_extractor.sv =====
// monochrome bitmap run extractor
// s_* takes the bitmap one byte per request, msb is the leftmost pixel,
// rows back to back and each row starting in a fresh byte. m_* gives one
// rectangle per request (x, y, length, color) with tlast on the final
// rectangle of a byte; bytes that only extend a run, or whose runs are
// transparent, give nothing. cfg_* writes the eight registers, index as
// listed in the package, and is always ready; write only while idle.
// eight bit lanes find the run breaks of a byte in the cycle it is taken,
// a merge stage then sends one rectangle per cycle while m_tready is high.
// the first rectangle of a byte passes the scan register, the merge
// stage and the output register. a byte gives at most nine rectangles,
// and the next byte can wait in the scan register while the merge sends.
// reset clears the control state and sets the registers to their reset
// values and starts a fresh row at y = 0. when m_tready is low the
// rectangle holds, one byte more waits in the merge stage and one in the
// scan register, after that s_tready drops.
module mono_bitmap_run_extractor
    import mbre_pkg::*;
#(
    parameter int COLOR_BITS = 32,
    parameter int COORD_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,     // data_byte
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [((2 * COORD_BITS + LEN_BITS + COLOR_BITS + 7) / 8) * 8 - 1:0]
                                    m_tdata,     // rect_x, rect_y, rect_length, rect_color
    output logic                    m_tlast,     // last_of_item
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    localparam int FIELD_BITS = 2 * COORD_BITS + LEN_BITS + COLOR_BITS;
    localparam int TDATA_BITS = ((FIELD_BITS + 7) / 8) * 8;

    logic [15:0]           start_x_reg;
    logic [LEN_BITS-1:0]   row_width_reg;
    logic [LANE_BITS-1:0]  bit_offset_reg;
    logic [COLOR_BITS-1:0] zero_color_reg;
    logic [COLOR_BITS-1:0] one_color_reg;
    logic                  zero_transparent_reg;
    logic                  one_transparent_reg;

    logic                  cfg_write;
    logic                  row_load;
    logic                  rec_valid;
    logic                  rec_take;
    mbre_evt_t             rec_evt;
    logic [COORD_BITS-1:0] rec_base_x, rec_run_start, rec_row_y;
    logic [LEN_BITS-1:0]   rec_run_count;
    logic [COORD_BITS-1:0] rect_x, rect_y;
    logic [LEN_BITS-1:0]   rect_length;
    logic [COLOR_BITS-1:0] rect_color;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign row_load  = cfg_write && (cfg_index == CFG_START_Y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg          <= '0;
            row_width_reg        <= LEN_BITS'(1);
            bit_offset_reg       <= '0;
            zero_color_reg       <= '0;
            one_color_reg        <= '0;
            zero_transparent_reg <= 1'b0;
            one_transparent_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_START_X:          start_x_reg          <= cfg_data[15:0];
                CFG_ROW_WIDTH:        row_width_reg        <= cfg_data[LEN_BITS-1:0];
                CFG_BIT_OFFSET:       bit_offset_reg       <= cfg_data[LANE_BITS-1:0];
                CFG_ZERO_COLOR:       zero_color_reg       <= COLOR_BITS'(cfg_data);
                CFG_ONE_COLOR:        one_color_reg        <= COLOR_BITS'(cfg_data);
                CFG_ZERO_TRANSPARENT: zero_transparent_reg <= cfg_data[0];
                CFG_ONE_TRANSPARENT:  one_transparent_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    mbre_scan #(
        .COORD_BITS (COORD_BITS)
    ) u_scan
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_byte          (s_tdata),
        .start_x          (COORD_BITS'(start_x_reg)),
        .row_width        (row_width_reg),
        .bit_offset       (bit_offset_reg),
        .zero_transparent (zero_transparent_reg),
        .one_transparent  (one_transparent_reg),
        .row_load         (row_load),
        .row_load_y       (COORD_BITS'(cfg_data[15:0])),
        .rec_valid        (rec_valid),
        .rec_take         (rec_take),
        .rec_evt          (rec_evt),
        .rec_base_x       (rec_base_x),
        .rec_run_start    (rec_run_start),
        .rec_row_y        (rec_row_y),
        .rec_run_count    (rec_run_count)
    );

    mbre_merge #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_merge
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (rec_valid),
        .rec_take      (rec_take),
        .rec_evt       (rec_evt),
        .rec_base_x    (rec_base_x),
        .rec_run_start (rec_run_start),
        .rec_row_y     (rec_row_y),
        .rec_run_count (rec_run_count),
        .zero_color    (zero_color_reg),
        .one_color     (one_color_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .rect_x        (rect_x),
        .rect_y        (rect_y),
        .rect_length   (rect_length),
        .rect_color    (rect_color),
        .last_of_item  (m_tlast)
    );

    assign m_tdata = TDATA_BITS'({rect_color, rect_length, rect_y, rect_x});

endmodule

// ===== rtl/core/mbre_lane.sv =====
module mbre_lane
(
    input  logic pix,
    input  logic prev,
    input  logic active,
    input  logic lead,
    input  logic count_zero,
    input  logic zero_transparent,
    input  logic one_transparent,
    output logic bnd,
    output logic emit
);

    logic prev_clear;

    assign prev_clear = prev ? one_transparent : zero_transparent;
    assign bnd        = active && (pix != prev);
    // an empty run at the row start gives no rectangle
    assign emit       = bnd && !prev_clear && !(lead && count_zero);

endmodule

// ===== rtl/core/mbre_scan.sv =====
module mbre_scan
    import mbre_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [LEN_BITS-1:0]   row_width,
    input  logic [LANE_BITS-1:0]  bit_offset,
    input  logic                  zero_transparent,
    input  logic                  one_transparent,
    input  logic                  row_load,
    input  logic [COORD_BITS-1:0] row_load_y,
    output logic                  rec_valid,
    input  logic                  rec_take,
    output mbre_evt_t             rec_evt,
    output logic [COORD_BITS-1:0] rec_base_x,
    output logic [COORD_BITS-1:0] rec_run_start,
    output logic [COORD_BITS-1:0] rec_row_y,
    output logic [LEN_BITS-1:0]   rec_run_count
);

    logic                  row_first_reg, row_first_next;
    logic [LEN_BITS-1:0]   pixels_left_reg, pixels_left_next;
    logic [COORD_BITS-1:0] run_start_reg, run_start_next;
    logic [LEN_BITS-1:0]   run_count_reg, run_count_next;
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic                  run_bit_reg, run_bit_next;
    logic [COORD_BITS-1:0] row_y_reg, row_y_next;

    logic                  rec_valid_reg;
    mbre_evt_t             rec_evt_reg;
    logic [COORD_BITS-1:0] rec_base_x_reg, rec_run_start_reg, rec_row_y_reg;
    logic [LEN_BITS-1:0]   rec_run_count_reg;

    logic                  accept;
    logic [LANE_BITS-1:0]  off;
    logic [LEN_BITS-1:0]   pl;
    logic [COORD_BITS-1:0] rs;
    logic [LEN_BITS-1:0]   rc;
    logic [COORD_BITS-1:0] cx;
    logic                  rb;
    logic [POS_BITS-1:0]   avail;
    logic                  row_end;
    logic [POS_BITS-1:0]   k;
    logic [POS_BITS-1:0]   pend;
    logic                  last_bit;
    logic [LANES-1:0]      pix, prev, active, lead, bnd, emit;
    logic [LANE_BITS-1:0]  last_bnd;
    logic                  any_bnd;
    mbre_evt_t             evt;

    assign accept   = in_valid && in_ready;
    assign in_ready = !rec_valid_reg || rec_take;

    always_comb
    begin
        off   = row_first_reg ? bit_offset : '0;
        pl    = row_first_reg ? ((row_width == '0) ? LEN_BITS'(1) : row_width)
                              : pixels_left_reg;
        rs    = row_first_reg ? start_x : run_start_reg;
        rc    = row_first_reg ? '0 : run_count_reg;
        cx    = row_first_reg ? start_x : cur_x_reg;
        rb    = row_first_reg ? 1'b0 : run_bit_reg;
        avail = POS_BITS'(LANES) - {1'b0, off};
        row_end = (pl <= LEN_BITS'(avail));
        k     = row_end ? pl[POS_BITS-1:0] : avail;
        pend  = {1'b0, off} + k;
    end

    genvar p;
    generate
        for (p = 0; p < LANES; p++)
        begin : g_lane
            assign pix[p]    = in_byte[LANES-1-p];
            assign lead[p]   = (LANE_BITS'(p) == off);
            assign active[p] = (POS_BITS'(p) >= {1'b0, off}) && (POS_BITS'(p) < pend);
            if (p == 0)
            begin : g_edge
                assign prev[p] = rb;
            end
            else
            begin : g_inner
                assign prev[p] = lead[p] ? rb : pix[p-1];
            end

            mbre_lane u_lane
            (
                .pix              (pix[p]),
                .prev             (prev[p]),
                .active           (active[p]),
                .lead             (lead[p]),
                .count_zero       (rc == '0),
                .zero_transparent (zero_transparent),
                .one_transparent  (one_transparent),
                .bnd              (bnd[p]),
                .emit             (emit[p])
            );
        end
    endgenerate

    // merge the lane flags into one event summary
    always_comb
    begin
        last_bit = pix[LANE_BITS'(pend - POS_BITS'(1))];
        last_bnd = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (bnd[i])
            begin
                last_bnd = LANE_BITS'(i);
            end
        end
        any_bnd = |bnd;

        evt.bnd      = {row_end, bnd};
        evt.emit     = {row_end && !(last_bit ? one_transparent : zero_transparent), emit};
        evt.cbit     = {last_bit, prev};
        evt.first    = off;
        evt.pend_pos = pend;
    end

    always_comb
    begin
        row_first_next   = row_first_reg;
        pixels_left_next = pixels_left_reg;
        run_start_next   = run_start_reg;
        run_count_next   = run_count_reg;
        cur_x_next       = cur_x_reg;
        run_bit_next     = run_bit_reg;
        row_y_next       = row_y_reg;
        if (row_load)
        begin
            row_first_next = 1'b1;
            row_y_next     = row_load_y;
        end
        else if (accept)
        begin
            row_first_next   = row_end;
            pixels_left_next = pl - LEN_BITS'(k);
            cur_x_next       = cx + COORD_BITS'(k);
            run_bit_next     = last_bit;
            if (any_bnd)
            begin
                run_start_next = cx + COORD_BITS'(LANE_BITS'(last_bnd - off));
                run_count_next = LEN_BITS'(pend - {1'b0, last_bnd});
            end
            else
            begin
                run_start_next = rs;
                run_count_next = rc + LEN_BITS'(k);
            end
            if (row_end)
            begin
                row_y_next = row_y_reg + COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_first_reg   <= 1'b1;
            pixels_left_reg <= LEN_BITS'(1);
            run_start_reg   <= '0;
            run_count_reg   <= '0;
            cur_x_reg       <= '0;
            run_bit_reg     <= 1'b0;
            row_y_reg       <= '0;
            rec_valid_reg   <= 1'b0;
        end
        else
        begin
            row_first_reg   <= row_first_next;
            pixels_left_reg <= pixels_left_next;
            run_start_reg   <= run_start_next;
            run_count_reg   <= run_count_next;
            cur_x_reg       <= cur_x_next;
            run_bit_reg     <= run_bit_next;
            row_y_reg       <= row_y_next;
            if (accept)
            begin
                rec_valid_reg <= 1'b1;
            end
            else if (rec_take)
            begin
                rec_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rec_evt_reg       <= evt;
            rec_base_x_reg    <= cx;
            rec_run_start_reg <= rs;
            rec_run_count_reg <= rc;
            rec_row_y_reg     <= row_y_reg;
        end
    end

    assign rec_valid     = rec_valid_reg;
    assign rec_evt       = rec_evt_reg;
    assign rec_base_x    = rec_base_x_reg;
    assign rec_run_start = rec_run_start_reg;
    assign rec_run_count = rec_run_count_reg;
    assign rec_row_y     = rec_row_y_reg;

endmodule

// ===== rtl/core/mbre_merge.sv =====
module mbre_merge
    import mbre_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int COLOR_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rec_valid,
    output logic                  rec_take,
    input  mbre_evt_t             rec_evt,
    input  logic [COORD_BITS-1:0] rec_base_x,
    input  logic [COORD_BITS-1:0] rec_run_start,
    input  logic [COORD_BITS-1:0] rec_row_y,
    input  logic [LEN_BITS-1:0]   rec_run_count,
    input  logic [COLOR_BITS-1:0] zero_color,
    input  logic [COLOR_BITS-1:0] one_color,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] rect_x,
    output logic [COORD_BITS-1:0] rect_y,
    output logic [LEN_BITS-1:0]   rect_length,
    output logic [COLOR_BITS-1:0] rect_color,
    output logic                  last_of_item
);

    logic [EVENTS-1:0]     pend_reg, pend_next;
    mbre_evt_t             evt_reg;
    logic [COORD_BITS-1:0] base_x_reg, run_start_reg, row_y_reg;
    logic [LEN_BITS-1:0]   run_count_reg;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] rect_x_reg, rect_y_reg;
    logic [LEN_BITS-1:0]   rect_length_reg;
    logic [COLOR_BITS-1:0] rect_color_reg;
    logic                  last_reg;

    logic                  out_free;
    logic                  busy;
    logic                  fire;
    logic                  work_take;
    logic                  load;
    logic [EVENTS-1:0]     sel;
    logic [EVENTS-1:0]     rest;
    logic [POS_BITS-1:0]   sel_idx;
    logic [POS_BITS-1:0]   pos;
    logic [LANE_BITS-1:0]  q;
    logic                  has_q;
    logic [COORD_BITS-1:0] x_calc;
    logic [LEN_BITS-1:0]   len_calc;

    assign out_free  = !out_valid_reg || out_ready;
    assign busy      = (pend_reg != '0);
    assign fire      = busy && out_free;
    assign sel       = pend_reg & (~pend_reg + EVENTS'(1));
    assign rest      = pend_reg & ~sel;
    assign work_take = !busy || (fire && (rest == '0));
    assign rec_take  = rec_valid && ((rec_evt.emit == '0) || work_take);
    assign load      = rec_take && (rec_evt.emit != '0);

    // next rectangle: the lowest pending event, started at the break before it
    always_comb
    begin
        sel_idx = '0;
        for (int i = EVENTS - 1; i >= 0; i--)
        begin
            if (sel[i])
            begin
                sel_idx = POS_BITS'(i);
            end
        end
        pos = (sel_idx == POS_BITS'(LANES)) ? evt_reg.pend_pos : sel_idx;
        q     = '0;
        has_q = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            if (evt_reg.bnd[i] && (POS_BITS'(i) < pos))
            begin
                q     = LANE_BITS'(i);
                has_q = 1'b1;
            end
        end
        if (has_q)
        begin
            x_calc   = base_x_reg + COORD_BITS'(LANE_BITS'(q - evt_reg.first));
            len_calc = LEN_BITS'(pos - {1'b0, q});
        end
        else
        begin
            x_calc   = run_start_reg;
            len_calc = run_count_reg + LEN_BITS'(pos - {1'b0, evt_reg.first});
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (fire)
        begin
            pend_next = rest;
        end
        if (load)
        begin
            pend_next = rec_evt.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            evt_reg       <= rec_evt;
            base_x_reg    <= rec_base_x;
            run_start_reg <= rec_run_start;
            run_count_reg <= rec_run_count;
            row_y_reg     <= rec_row_y;
        end
        if (fire)
        begin
            rect_x_reg      <= x_calc;
            rect_y_reg      <= row_y_reg;
            rect_length_reg <= len_calc;
            rect_color_reg  <= ((evt_reg.cbit & sel) != '0) ? one_color : zero_color;
            last_reg        <= (rest == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign rect_x       = rect_x_reg;
    assign rect_y       = rect_y_reg;
    assign rect_length  = rect_length_reg;
    assign rect_color   = rect_color_reg;
    assign last_of_item = last_reg;

endmodule

// ===== dv/mbre_rect_checker.sv =====
`timescale 1ns / 1ps

module mbre_rect_checker
    import mbre_pkg::*;
#(
    parameter int RECT_BITS = 80
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [7:0]              s_tdata,     // data_byte
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [RECT_BITS-1:0]    m_tdata,     // rect_x, rect_y, rect_length, rect_color
    input  logic                    m_tlast,     // last_of_item
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    output int                      errors,
    output int                      pending
);

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] len;
        logic [31:0] color;
        logic        tl;
    } rect_t;

    rect_t rects_due[$];

    // register copies
    logic [15:0] reg_start_x;
    logic [15:0] reg_width;
    logic [2:0]  reg_offset;
    logic [31:0] reg_zero_color;
    logic [31:0] reg_one_color;
    logic        reg_zero_clear;
    logic        reg_one_clear;

    // scan state
    logic [15:0] px_left;
    logic [15:0] run_len;
    logic [15:0] run_x;
    logic [15:0] row_y;
    logic        row_first;
    logic        run_bit;
    int          byte_rects;
    int          rect_num;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors = errors + 1;
        if (errors <= 100)
            $display("rect %0d %s: got %h, expected %h", rect_num, what, got, want);
    endtask

    // closes the current run, transparent or empty runs give no rectangle
    task automatic close_run();
        rect_t r;
        if (run_len != 0 && !(run_bit ? reg_one_clear : reg_zero_clear))
        begin
            r.x     = run_x;
            r.y     = row_y;
            r.len   = run_len;
            r.color = run_bit ? reg_one_color : reg_zero_color;
            r.tl    = 1'b0;
            rects_due.push_back(r);
            byte_rects++;
        end
    endtask

    task automatic scan_byte(input logic [7:0] d);
        int    b;
        rect_t r;
        b = 7;
        byte_rects = 0;
        if (row_first)
        begin
            row_first = 1'b0;
            px_left   = (reg_width == 16'd0) ? 16'd1 : reg_width;
            run_x     = reg_start_x;
            run_bit   = 1'b0;
            run_len   = 16'd0;
            b         = 7 - int'(reg_offset);
        end
        while (b >= 0 && px_left != 16'd0)
        begin
            if (d[b] == run_bit)
                run_len = run_len + 16'd1;
            else
            begin
                close_run();
                run_x   = run_x + run_len;
                run_len = 16'd1;
                run_bit = d[b];
            end
            px_left = px_left - 16'd1;
            // rest of the byte past the row end is dropped
            if (px_left == 16'd0)
            begin
                close_run();
                row_y     = row_y + 16'd1;
                row_first = 1'b1;
            end
            b--;
        end
        if (byte_rects > 0)
        begin
            r = rects_due[rects_due.size() - 1];
            r.tl = 1'b1;
            rects_due[rects_due.size() - 1] = r;
        end
    endtask

    always @(posedge clk)
    begin
        rect_t got;
        rect_t want;
        if (!rst_n)
        begin
            reg_start_x    = 16'd0;
            reg_width      = 16'd1;
            reg_offset     = 3'd0;
            reg_zero_color = 32'd0;
            reg_one_color  = 32'd0;
            reg_zero_clear = 1'b0;
            reg_one_clear  = 1'b0;
            px_left        = 16'd1;
            run_len        = 16'd0;
            run_x          = 16'd0;
            row_y          = 16'd0;
            row_first      = 1'b1;
            run_bit        = 1'b0;
            rect_num       = 0;
            rects_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.x     = m_tdata[15:0];
                got.y     = m_tdata[31:16];
                got.len   = m_tdata[47:32];
                got.color = m_tdata[79:48];
                got.tl    = m_tlast;
                if (rects_due.size() == 0)
                    report_mismatch("arrived with none expected, x", 32'(got.x), 32'd0);
                else
                begin
                    want = rects_due.pop_front();
                    if (got.x !== want.x)
                        report_mismatch("rect_x", 32'(got.x), 32'(want.x));
                    if (got.y !== want.y)
                        report_mismatch("rect_y", 32'(got.y), 32'(want.y));
                    if (got.len !== want.len)
                        report_mismatch("rect_length", 32'(got.len), 32'(want.len));
                    if (got.color !== want.color)
                        report_mismatch("rect_color", got.color, want.color);
                    if (got.tl !== want.tl)
                        report_mismatch("last_of_item", 32'(got.tl), 32'(want.tl));
                end
                rect_num++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_START_X:          reg_start_x = cfg_data[15:0];
                    CFG_START_Y:
                    begin
                        row_y       = cfg_data[15:0];
                        row_first   = 1'b1;
                    end
                    CFG_ROW_WIDTH:        reg_width      = cfg_data[15:0];
                    CFG_BIT_OFFSET:       reg_offset     = cfg_data[2:0];
                    CFG_ZERO_COLOR:       reg_zero_color = cfg_data[31:0];
                    CFG_ONE_COLOR:        reg_one_color  = cfg_data[31:0];
                    CFG_ZERO_TRANSPARENT: reg_zero_clear = cfg_data[0];
                    CFG_ONE_TRANSPARENT:  reg_one_clear  = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                scan_byte(s_tdata);
        end
        pending <= rects_due.size();
    end

endmodule

// ===== dv/tb_mono_bitmap_run_extractor.sv =====
`timescale 1ns / 1ps

module tb_mono_bitmap_run_extractor;
    import mbre_pkg::*;

    localparam int RECT_BITS     = 80;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES        = 12;
    localparam int PHASE_BYTES   = 40;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata   = 8'd0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [RECT_BITS-1:0]    m_tdata;
    logic                    m_tlast;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_data  = '0;

    int errors;
    int pending;
    bit tx_gap_en   = 1'b0;
    bit rx_stall_en = 1'b0;
    int rx_hold     = 0;
    int idle_cycles = 0;

    always #1 clk = ~clk;

    mono_bitmap_run_extractor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mbre_rect_checker #(.RECT_BITS(RECT_BITS)) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int stall_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // result sink with random stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end
        else if (rx_hold > 0)
            rx_hold <= rx_hold - 1;
        else if (!rx_stall_en)
            m_tready <= 1'b1;
        else if (m_tready && $urandom_range(0, 99) < 35)
        begin
            m_tready <= 1'b0;
            rx_hold  <= stall_len() - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_hold  <= $urandom_range(0, 6);
        end
    end

    // counts cycles without any request moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0, 1:    return 32'd0;
            2:       return 32'd65535 - $urandom_range(0, 12);
            3:       return 32'd65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [31:0] pick_width();
        int p;
        p = $urandom_range(0, 19);
        if (p == 0)
            return 32'd0;
        if (p == 1)
            return 32'd65535;
        if (p == 2)
            return 32'd1;
        if (p < 13)
            return $urandom_range(1, 16);
        if (p < 18)
            return $urandom_range(17, 64);
        return $urandom_range(65, 300);
    endfunction

    // small fields sometimes carry junk in the unused upper bits
    function automatic logic [31:0] pick_offset();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'd0;
            1:       v = 32'd7;
            default: v = $urandom_range(0, 7);
        endcase
        if ($urandom_range(0, 9) == 0)
            v = ($urandom() & 32'hFFFF_FFF8) | v;
        return v;
    endfunction

    function automatic logic [31:0] pick_color();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_flag();
        logic [31:0] v;
        v = ($urandom_range(0, 4) == 0) ? 32'd1 : 32'd0;
        if ($urandom_range(0, 9) == 0)
            v = ($urandom() & 32'hFFFF_FFFE) | v;
        return v;
    endfunction

    function automatic logic [7:0] pick_byte(input int style);
        int p;
        p = $urandom_range(0, 9);
        if (style == 1 && p < 7)
        begin
            case ($urandom_range(0, 5))
                0:       return 8'h00;
                1:       return 8'hFF;
                2:       return 8'hF0;
                3:       return 8'h0F;
                4:       return 8'h80;
                default: return 8'h01;
            endcase
        end
        if (style == 2 && p < 6)
            return (p < 3) ? 8'hAA : 8'h55;
        return $urandom_range(0, 255);
    endfunction

    task automatic send_byte(input logic [7:0] d);
        int gap;
        gap = tx_gap_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every pending rectangle, then let bytes without output finish
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_setup();
        write_reg(CFG_START_X, pick_coord());
        write_reg(CFG_START_Y, pick_coord());
        write_reg(CFG_ROW_WIDTH, pick_width());
        write_reg(CFG_BIT_OFFSET, pick_offset());
        write_reg(CFG_ZERO_COLOR, pick_color());
        write_reg(CFG_ONE_COLOR, pick_color());
        write_reg(CFG_ZERO_TRANSPARENT, pick_flag());
        write_reg(CFG_ONE_TRANSPARENT, pick_flag());
    endtask

    initial
    begin
        int style;
        int ev;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: one pixel rows
        send_byte(8'h80);
        send_byte(8'h7F);
        settle();

        // x and y wrap, row ends inside a byte
        write_reg(CFG_START_X, 32'd65530);
        write_reg(CFG_START_Y, 32'd65535);
        write_reg(CFG_ROW_WIDTH, 32'd20);
        write_reg(CFG_BIT_OFFSET, 32'd3);
        write_reg(CFG_ZERO_COLOR, 32'h1234_5678);
        write_reg(CFG_ONE_COLOR, 32'hFFFF_FFFF);
        write_reg(CFG_ZERO_TRANSPARENT, 32'd0);
        write_reg(CFG_ONE_TRANSPARENT, 32'd0);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hAA);
        send_byte(8'h13);
        send_byte(8'hC4);
        send_byte(8'h55);
        settle();

        // nine rectangles from one byte, then a run spanning two bytes
        write_reg(CFG_START_X, 32'd0);
        write_reg(CFG_START_Y, 32'd100);
        write_reg(CFG_ROW_WIDTH, 32'd16);
        write_reg(CFG_BIT_OFFSET, 32'd0);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'h00);
        send_byte(8'h00);
        settle();

        // transparent zero runs, then both transparent
        write_reg(CFG_ZERO_TRANSPARENT, 32'd1);
        send_byte(8'h55);
        send_byte(8'h0F);
        settle();
        write_reg(CFG_ONE_TRANSPARENT, 32'd1);
        send_byte(8'hA5);
        send_byte(8'h3C);
        settle();
        write_reg(CFG_ZERO_TRANSPARENT, 32'd0);
        send_byte(8'h96);
        send_byte(8'h00);
        settle();

        // zero width acts as one pixel, taken from the lsb
        write_reg(CFG_ONE_TRANSPARENT, 32'd0);
        write_reg(CFG_ROW_WIDTH, 32'd0);
        write_reg(CFG_BIT_OFFSET, 32'd7);
        send_byte(8'h01);
        send_byte(8'hFE);
        settle();

        // widest row, cut short by a start_y write
        write_reg(CFG_ROW_WIDTH, 32'd65535);
        send_byte(8'h01);
        send_byte(8'hFF);
        settle();
        write_reg(CFG_START_Y, 32'd9);
        write_reg(CFG_ROW_WIDTH, 32'd3);
        write_reg(CFG_BIT_OFFSET, 32'd0);
        send_byte(8'hE0);
        settle();

        // color change inside a run applies at once
        write_reg(CFG_ROW_WIDTH, 32'd12);
        send_byte(8'hF0);
        settle();
        write_reg(CFG_ZERO_COLOR, 32'hA5A5_A5A5);
        send_byte(8'h0F);
        settle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            tx_gap_en   <= ($urandom_range(0, 3) != 0);
            rx_stall_en <= ($urandom_range(0, 3) != 0);
            style = $urandom_range(0, 2);
            ev    = (ph == 1) ? 0 : $urandom_range(0, 4);
            load_setup();
            for (int k = 0; k < PHASE_BYTES; k++)
            begin
                if (k == PHASE_BYTES / 2)
                begin
                    case (ev)
                        0: settle();
                        1:
                        begin
                            settle();
                            write_reg(CFG_ONE_COLOR, pick_color());
                            write_reg(CFG_ZERO_TRANSPARENT, pick_flag());
                        end
                        2:
                        begin
                            settle();
                            write_reg(CFG_START_Y, pick_coord());
                        end
                        3:
                        begin
                            // these apply from the next row on
                            settle();
                            write_reg(CFG_START_X, pick_coord());
                            write_reg(CFG_ROW_WIDTH, pick_width());
                            write_reg(CFG_BIT_OFFSET, pick_offset());
                        end
                        default: ;
                    endcase
                end
                send_byte(pick_byte(style));
            end
            settle();
        end

        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
